### rtl/imutcf_pkg.sv
package imutcf_pkg;

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 8'd1;

  // gyro increment divisor: 131 counts per deg/s times 1000 steps per second
  localparam logic [17:0] GYRO_DIV  = 18'd131000;
  localparam logic [17:0] GYRO_HALF = 18'd65500;
  // filter blend 19/20 against 1/20
  localparam logic [17:0] FILT_DIV  = 18'd20;
  localparam logic [17:0] FILT_HALF = 18'd10;

  localparam int unsigned DIV_W   = 42;
  localparam int unsigned REM_W   = 18;
  localparam int unsigned XY_W    = 28;
  localparam int unsigned Z_W     = 34;
  localparam int unsigned ROOT_W  = 24;
  localparam int unsigned SQ_W    = 48;
  localparam int unsigned ATAN_LEN = 24;

  // reciprocal division: dividend below 2^38, reciprocal floor(2^38 / d)
  localparam int unsigned DM_W    = 38;
  localparam int unsigned HALF_W  = 19;
  localparam int unsigned RECIP_W = 34;
  localparam int unsigned PP_W    = HALF_W + RECIP_W;
  localparam int unsigned Q_W     = 34;
  localparam logic [RECIP_W-1:0] GYRO_RECIP = 34'd2098304;
  localparam logic [RECIP_W-1:0] FILT_RECIP = 34'd13743895347;

  localparam logic signed [Z_W-1:0] QUARTER_TURN = 34'sd1073741824;

  localparam logic [1:0] PH_GX    = 2'd0;
  localparam logic [1:0] PH_GY    = 2'd1;
  localparam logic [1:0] PH_ROLL  = 2'd2;
  localparam logic [1:0] PH_PITCH = 2'd3;

  localparam logic PASS_ROLL  = 1'b0;
  localparam logic PASS_PITCH = 1'b1;

  typedef struct packed {
    logic signed [16:0] gx;
    logic signed [16:0] gy;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } sample_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [29:0] atan_turn(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/imutcf_front.sv
module imutcf_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [15:0]                 gyro_rate_x,
  input  logic signed [15:0]                 gyro_rate_y,
  input  logic signed [15:0]                 accel_raw_x,
  input  logic signed [15:0]                 accel_raw_y,
  input  logic signed [15:0]                 accel_raw_z,
  input  logic                               cfg_we,
  input  logic [imutcf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                        cfg_data,
  output logic                               q_valid,
  output imutcf_pkg::sample_t                q_item,
  input  logic                               q_pop
);
  import imutcf_pkg::*;

  logic signed [15:0] offset_x;
  logic signed [15:0] offset_y;
  sample_t            fifo [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;
  logic               push;
  logic               pop;
  sample_t            item;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = fifo[rd_ptr];

  always_comb begin
    item.gx = {gyro_rate_x[15], gyro_rate_x} - {offset_x[15], offset_x};
    item.gy = {gyro_rate_y[15], gyro_rate_y} - {offset_y[15], offset_y};
    item.ax = accel_raw_x;
    item.ay = accel_raw_y;
    item.az = accel_raw_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0;
      offset_y <= '0;
      wr_ptr   <= 1'b0;
      rd_ptr   <= 1'b0;
      count    <= 2'd0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_OFFSET_X) begin
          offset_x <= cfg_data;
        end else if (cfg_index == REG_OFFSET_Y) begin
          offset_y <= cfg_data;
        end
      end
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= item;
    end
  end

endmodule

### rtl/imutcf_back.sv
module imutcf_back #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  imutcf_pkg::sample_t q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  fused_roll,
  output logic signed [31:0]  fused_pitch,
  output logic signed [24:0]  accel_roll,
  output logic signed [23:0]  accel_pitch
);
  import imutcf_pkg::*;

  localparam int ANG_W = ANGLE_FRAC_BITS + 10;
  localparam int RS    = 32 - ANGLE_FRAC_BITS;
  localparam int P_W   = Z_W + 9;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_SQA   = 14'b00000000000010,
    S_SQB   = 14'b00000000000100,
    S_ROOT  = 14'b00000000001000,
    S_CLOAD = 14'b00000000010000,
    S_CITER = 14'b00000000100000,
    S_CMUL  = 14'b00000001000000,
    S_CRND  = 14'b00000010000000,
    S_DLOAD = 14'b00000100000000,
    S_DMUL  = 14'b00001000000000,
    S_DEST  = 14'b00010000000000,
    S_DFIX  = 14'b00100000000000,
    S_DDONE = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  state_t                  state;
  logic [5:0]              cnt;
  sample_t                 smp;
  logic [31:0]             sq_a;
  logic [SQ_W-1:0]         sq;
  logic [ROOT_W+2:0]       rrem;
  logic [ROOT_W-1:0]       root;
  logic                    pass;
  logic                    zero;
  logic signed [XY_W-1:0]  cx;
  logic signed [XY_W-1:0]  cy;
  logic signed [Z_W-1:0]   cz;
  logic signed [P_W-1:0]   prod;
  logic signed [ANG_W-1:0] roll_acc;
  logic signed [ANG_W-1:0] pitch_acc;
  logic [1:0]              phase;
  logic                    dneg;
  logic [DM_W-1:0]         dm;
  logic [PP_W-1:0]         dph;
  logic [PP_W-1:0]         dpl;
  logic [Q_W-1:0]          dest;
  logic [Q_W-1:0]          dq;
  logic signed [31:0]      step_x;
  logic signed [31:0]      step_y;
  logic signed [31:0]      new_roll;
  logic signed [31:0]      new_pitch;
  logic signed [31:0]      roll_est;
  logic signed [31:0]      pitch_est;

  // square root step
  logic [ROOT_W+4:0]       rsh;
  logic [ROOT_W+4:0]       rtrial;
  // cordic
  logic signed [XY_W-1:0]  ld_x;
  logic signed [XY_W-1:0]  ld_y;
  logic signed [XY_W-1:0]  xsh;
  logic signed [XY_W-1:0]  ysh;
  logic signed [Z_W-1:0]   atan_ext;
  logic signed [P_W-1:0]   zext;
  logic [P_W-1:0]          pmag;
  logic [P_W-1:0]          rmag;
  logic signed [P_W:0]     rres;
  logic signed [P_W:0]     rlim;
  logic signed [ANG_W-1:0] rclamp;
  // divider
  logic signed [DIV_W-1:0] num;
  logic signed [DIV_W-1:0] blend;
  logic signed [DIV_W-1:0] acc_ext;
  logic [DIV_W-1:0]        dmag;
  logic [REM_W-1:0]        dvsr;
  logic [REM_W-1:0]        dhalf;
  logic [RECIP_W-1:0]      drecip;
  logic [PP_W+HALF_W-1:0]  dsum;
  logic [Q_W+REM_W-1:0]    dback;
  logic [DM_W-1:0]         dleft;
  logic                    dge;
  logic signed [DIV_W-1:0] dres;
  logic signed [31:0]      dclamp;
  logic                    out_load;
  logic [63:0]             roll_wide;
  logic [63:0]             pitch_wide;

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  always_comb begin
    rsh    = {rrem, sq[SQ_W-1 -: 2]};
    rtrial = {3'b000, root, 2'b01};
  end

  always_comb begin
    if (pass == PASS_PITCH) begin
      ld_y = XY_W'({{(XY_W-24){smp.ax[15]}}, smp.ax, 8'h00});
      ld_x = XY_W'({{(XY_W-ROOT_W){1'b0}}, root});
    end else begin
      ld_y = XY_W'({{(XY_W-16){smp.ay[15]}}, smp.ay});
      ld_x = XY_W'({{(XY_W-16){smp.az[15]}}, smp.az});
    end
    xsh      = cx >>> cnt[4:0];
    ysh      = cy >>> cnt[4:0];
    atan_ext = Z_W'({4'b0000, atan_turn(cnt[4:0])});
    zext     = P_W'({{(P_W-Z_W){cz[Z_W-1]}}, cz});
  end

  // degrees = round(turns * 360 / 2^(32-F)), clamped to +/-90 for pitch and +/-180 for roll
  always_comb begin
    pmag   = prod[P_W-1] ? P_W'(-prod) : P_W'(prod);
    rmag   = (pmag + (P_W'(1) << (RS - 1))) >> RS;
    rres   = prod[P_W-1] ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
    rlim   = (pass == PASS_PITCH) ? ((P_W+1)'(90) <<< ANGLE_FRAC_BITS)
                                  : ((P_W+1)'(180) <<< ANGLE_FRAC_BITS);
    if (rres > rlim) begin
      rclamp = rlim[ANG_W-1:0];
    end else if (rres < -rlim) begin
      rclamp = ANG_W'(-rlim);
    end else begin
      rclamp = rres[ANG_W-1:0];
    end
  end

  always_comb begin
    if (phase == PH_ROLL) begin
      acc_ext = DIV_W'({{(DIV_W-ANG_W){roll_acc[ANG_W-1]}}, roll_acc});
      blend   = DIV_W'({{(DIV_W-32){roll_est[31]}}, roll_est})
              + DIV_W'({{(DIV_W-32){step_x[31]}}, step_x});
    end else begin
      acc_ext = DIV_W'({{(DIV_W-ANG_W){pitch_acc[ANG_W-1]}}, pitch_acc});
      blend   = DIV_W'({{(DIV_W-32){pitch_est[31]}}, pitch_est})
              + DIV_W'({{(DIV_W-32){step_y[31]}}, step_y});
    end
    case (phase)
      PH_GX:   num = DIV_W'({{(DIV_W-17){smp.gx[16]}}, smp.gx}) <<< ANGLE_FRAC_BITS;
      PH_GY:   num = DIV_W'({{(DIV_W-17){smp.gy[16]}}, smp.gy}) <<< ANGLE_FRAC_BITS;
      default: num = (blend <<< 4) + (blend <<< 1) + blend + acc_ext;
    endcase
    if (phase == PH_GX || phase == PH_GY) begin
      dvsr   = GYRO_DIV;
      dhalf  = GYRO_HALF;
      drecip = GYRO_RECIP;
    end else begin
      dvsr   = FILT_DIV;
      dhalf  = FILT_HALF;
      drecip = FILT_RECIP;
    end
    dmag  = num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
    // the reciprocal estimate is at most one short: one trial subtract settles it
    dsum  = {dph, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, dpl};
    dback = dest * dvsr;
    dleft = dm - dback[DM_W-1:0];
    dge   = (dleft >= {{(DM_W-REM_W){1'b0}}, dvsr});
    dres  = dneg ? -$signed({{(DIV_W-Q_W){1'b0}}, dq})
                 : $signed({{(DIV_W-Q_W){1'b0}}, dq});
    if (dres > DIV_W'(32'sh7FFFFFFF)) begin
      dclamp = 32'sh7FFFFFFF;
    end else if (dres < -DIV_W'(33'sh080000000)) begin
      dclamp = 32'sh80000000;
    end else begin
      dclamp = dres[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      roll_est  <= '0;
      pitch_est <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        roll_est  <= new_roll;
        pitch_est <= new_pitch;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE:  if (q_valid) state <= S_SQA;
        S_SQA:   state <= S_SQB;
        S_SQB:   state <= S_ROOT;
        S_ROOT:  if (cnt == 6'(ROOT_W - 1)) state <= S_CLOAD;
        S_CLOAD: state <= S_CITER;
        S_CITER: if (cnt == 6'(CORDIC_STEPS - 1)) state <= S_CMUL;
        S_CMUL:  state <= S_CRND;
        S_CRND:  state <= (pass == PASS_ROLL) ? S_CLOAD : S_DLOAD;
        S_DLOAD: state <= S_DMUL;
        S_DMUL:  state <= S_DEST;
        S_DEST:  state <= S_DFIX;
        S_DFIX:  state <= S_DDONE;
        S_DDONE: state <= (phase == PH_PITCH) ? S_OUT : S_DLOAD;
        S_OUT:   if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        smp  <= q_item;
        pass <= PASS_ROLL;
      end
      S_SQA: begin
        sq_a <= 32'(smp.ay * smp.ay);
      end
      S_SQB: begin
        sq   <= {sq_a + 32'(smp.az * smp.az), 16'h0000};
        rrem <= '0;
        root <= '0;
        cnt  <= '0;
      end
      S_ROOT: begin
        // bring down two bits, keep a root bit when the trial fits
        if (rsh >= rtrial) begin
          rrem <= (ROOT_W+3)'(rsh - rtrial);
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rrem <= rsh[ROOT_W+2:0];
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        sq  <= sq << 2;
        cnt <= cnt + 6'd1;
      end
      S_CLOAD: begin
        zero <= (ld_x == '0) && (ld_y == '0);
        cnt  <= '0;
        // pre-rotate the left half plane by a quarter turn
        if (ld_x < 0) begin
          if (ld_y >= 0) begin
            cx <= ld_y;
            cy <= -ld_x;
            cz <= QUARTER_TURN;
          end else begin
            cx <= -ld_y;
            cy <= ld_x;
            cz <= -QUARTER_TURN;
          end
        end else begin
          cx <= ld_x;
          cy <= ld_y;
          cz <= '0;
        end
      end
      S_CITER: begin
        if (cy >= 0) begin
          cx <= cx + ysh;
          cy <= cy - xsh;
          cz <= cz + atan_ext;
        end else begin
          cx <= cx - ysh;
          cy <= cy + xsh;
          cz <= cz - atan_ext;
        end
        cnt <= cnt + 6'd1;
      end
      S_CMUL: begin
        if (zero) begin
          prod <= '0;
        end else begin
          prod <= (zext <<< 8) + (zext <<< 6) + (zext <<< 5) + (zext <<< 3);
        end
      end
      S_CRND: begin
        if (pass == PASS_ROLL) begin
          roll_acc <= rclamp;
          pass     <= PASS_PITCH;
        end else begin
          pitch_acc <= rclamp;
          phase     <= PH_GX;
        end
      end
      S_DLOAD: begin
        dneg <= num[DIV_W-1];
        dm   <= dmag[DM_W-1:0] + {{(DM_W-REM_W){1'b0}}, dhalf};
      end
      S_DMUL: begin
        dph <= dm[DM_W-1:HALF_W] * drecip;
        dpl <= dm[HALF_W-1:0] * drecip;
      end
      S_DEST: begin
        dest <= dsum[PP_W+HALF_W-1 -: Q_W];
      end
      S_DFIX: begin
        dq <= dest + {{(Q_W-1){1'b0}}, dge};
      end
      S_DDONE: begin
        case (phase)
          PH_GX:   step_x    <= dres[31:0];
          PH_GY:   step_y    <= dres[31:0];
          PH_ROLL: new_roll  <= dclamp;
          default: new_pitch <= dclamp;
        endcase
        phase <= phase + 2'd1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    roll_wide  = 64'({{(64-ANG_W){roll_acc[ANG_W-1]}}, roll_acc});
    pitch_wide = 64'({{(64-ANG_W){pitch_acc[ANG_W-1]}}, pitch_acc});
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      fused_roll  <= new_roll;
      fused_pitch <= new_pitch;
      accel_roll  <= roll_wide[24:0];
      accel_pitch <= pitch_wide[23:0];
    end
  end

endmodule

### rtl/imu_tilt_complementary_filter.sv
// Tilt estimator: fuses gyro rates with accelerometer tilt, one result per sample set.
// Input channel: in_valid / in_stall with gyro_rate_x/y and accel_raw_x/y/z. A sample
// is taken when in_valid is high and in_stall low; a two-entry queue holds samples
// while the arithmetic sequencer is busy, and in_stall rises only when it is full.
// Output channel: out_valid / out_stall with fused_roll, fused_pitch, accel_roll and
// accel_pitch. A result stays in the output register while out_stall is high; the
// sequencer finishes the next sample and waits for that register to free up.
// Configuration: cfg_valid / cfg_ready (always ready), cfg_index selects the gyro
// offset (0 for x, 1 for y), cfg_data holds it; other indexes are dropped. Write
// offsets only while no sample is in flight.
// Sequence: each sample goes through squaring, a bit-serial square root, two CORDIC
// passes (roll, then pitch), four constant divisions by reciprocal multiply (two gyro
// increments, then the roll and pitch blends) and the output load. The sequencer takes
// the next sample from the queue only once it is idle again, after the previous result
// has been loaded into the output register; it waits longer while out_stall holds a
// finished result.
// Reset (rst, synchronous) clears the offsets, both filter estimates, the queue and
// the output valid.
module imu_tilt_complementary_filter #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [15:0]               gyro_rate_x,
  input  logic signed [15:0]               gyro_rate_y,
  input  logic signed [15:0]               accel_raw_x,
  input  logic signed [15:0]               accel_raw_y,
  input  logic signed [15:0]               accel_raw_z,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [31:0]               fused_roll,
  output logic signed [31:0]               fused_pitch,
  output logic signed [24:0]               accel_roll,
  output logic signed [23:0]               accel_pitch,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [imutcf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                      cfg_data
);
  import imutcf_pkg::*;

  logic    q_valid;
  logic    q_pop;
  sample_t q_item;

  assign cfg_ready = 1'b1;

  imutcf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .gyro_rate_x (gyro_rate_x),
    .gyro_rate_y (gyro_rate_y),
    .accel_raw_x (accel_raw_x),
    .accel_raw_y (accel_raw_y),
    .accel_raw_z (accel_raw_z),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  imutcf_back #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .fused_roll  (fused_roll),
    .fused_pitch (fused_pitch),
    .accel_roll  (accel_roll),
    .accel_pitch (accel_pitch)
  );

endmodule
